[rtl/core/top_band_centroid_macros.svh]
// Assertion macros used by the core control module.
`ifndef TOP_BAND_CENTROID_MACROS_SVH
`define TOP_BAND_CENTROID_MACROS_SVH

// Antecedent implies consequent on the next edge.
`define TBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent on the same edge.
`define TBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/tbc_pkg.sv]
package tbc_pkg;
    localparam int MaxPoints = 1024;
    localparam int AddrW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int CoordW = 18;
    localparam int SumW = CoordW + CntW;

    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusFew = 2'd1;
    localparam logic [1:0] StatusEmpty = 2'd2;

    localparam logic [1:0] RegBandWidth = 2'd0;
    localparam logic [1:0] RegMinPoints = 2'd1;
    localparam logic [1:0] RegMissLimit = 2'd2;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
    } point_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_wr;   // write the incoming point, bump the count
        logic clear_cnt;  // end of cloud
        logic rd_en;      // read the store at scan_addr
        logic max_acc;    // fold a read value into max z
        logic max_init;   // first read of the max pass
        logic band_acc;   // fold a read value into the band sums
        logic band_init;  // clear sums before the band pass
        logic div_start;  // begin the three divisions
        logic div_step;   // one restoring step
        logic fin_few;    // form a too-few result
        logic fin_norm;   // form a normal result
        logic [AddrW-1:0] scan_addr;
    } tbc_cmd_t;

    typedef struct packed {
        logic [CntW-1:0] count;  // points held, before any write in this cycle
        logic            full;
    } tbc_stat_t;
endpackage

[rtl/core/tbc_stream_if.sv]
interface tbc_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/core/tbc_ctrl.sv]
module tbc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  logic [10:0]           min_points,
    input  tbc_pkg::tbc_stat_t    stat,
    output tbc_pkg::tbc_cmd_t     cmd
);
    import tbc_pkg::*;
    `include "top_band_centroid_macros.svh"

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_MAX  = 7'b0000010,
        S_BAND = 7'b0000100,
        S_DIVS = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CntW-1:0] n_reg, n_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [5:0] step_reg, step_next;
    logic first_reg, first_next;
    logic accept;

    assign in_ready = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        first_next = first_reg;
        cmd = '0;
        cmd.scan_addr = idx_reg[AddrW-1:0];
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.store_wr = !stat.full;
                    if (in_last)
                    begin
                        cmd.clear_cnt = 1'b1;
                        n_next = stat.full ? stat.count : stat.count + 1'b1;
                        idx_next = '0;
                        first_next = 1'b1;
                        if ((stat.full ? stat.count : stat.count + 1'b1) < min_points)
                            state_next = S_FIN;
                        else
                            state_next = S_MAX;
                    end
                end
            end
            // Read addresses run one ahead of the accumulate with registered read data.
            S_MAX:
            begin
                cmd.rd_en = (idx_reg < n_reg);
                cmd.max_acc = !first_reg;
                cmd.max_init = (idx_reg == CntW'(1));
                first_next = 1'b0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_reg)
                begin
                    idx_next = '0;
                    first_next = 1'b1;
                    state_next = S_BAND;
                end
            end
            S_BAND:
            begin
                cmd.rd_en = (idx_reg < n_reg);
                cmd.band_init = first_reg;
                cmd.band_acc = !first_reg;
                first_next = 1'b0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_reg)
                    state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                step_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == 6'(SumW - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin_few = first_reg;
                cmd.fin_norm = !first_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_LOAD;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            n_reg <= '0;
            idx_reg <= '0;
            step_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            idx_reg <= idx_next;
            step_reg <= step_next;
            first_reg <= first_next;
        end
    end

    `TBC_ASSERT_SAME(a_one_side, in_ready, !out_valid, "input and output both open")
    `TBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `TBC_ASSERT_NEXT(a_div_len, state_reg == S_DIVS, state_reg == S_DIV, "divide skipped")
    `TBC_ASSERT_SAME(a_scan_n, state_reg == S_MAX, n_reg >= CntW'(1), "empty scan")
endmodule

[rtl/core/tbc_datapath.sv]
module tbc_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tbc_pkg::point_t          pt,
    input  logic                     detection_seen,
    input  logic [13:0]              band_width,
    input  logic [7:0]               miss_limit,
    input  tbc_pkg::tbc_cmd_t        cmd,
    output tbc_pkg::tbc_stat_t       stat,
    output logic [17:0]              centroid_x,
    output logic [17:0]              centroid_y,
    output logic [17:0]              centroid_z,
    output logic [10:0]              band_count,
    output logic [1:0]               status,
    output logic                     depth_only_mode
);
    import tbc_pkg::*;

    point_t mem [MaxPoints];
    point_t rd_reg;
    logic [CntW-1:0] cnt_reg;
    logic [7:0] miss_reg;
    logic det_reg;
    logic signed [CoordW-1:0] max_reg;
    logic signed [CoordW:0] lo_z;
    logic signed [SumW-1:0] sx_reg, sy_reg, sz_reg;
    logic [CntW-1:0] bc_reg;
    // Restoring dividers on magnitudes.
    logic [SumW-1:0] qx_reg, qy_reg, qz_reg;
    logic [CntW:0] rx_reg, ry_reg, rz_reg;
    logic negx_reg, negy_reg, negz_reg;
    logic [17:0] cx_reg, cy_reg, cz_reg;
    logic [10:0] bco_reg;
    logic [1:0] st_reg;
    logic dom_reg;
    logic in_band;
    logic [CntW:0] tx, ty, tz;
    logic [SumW-1:0] cx_q, cy_q, cz_q;

    assign stat.count = cnt_reg;
    assign stat.full = (cnt_reg == CntW'(MaxPoints));

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
            mem[cnt_reg[AddrW-1:0]] <= pt;
        if (cmd.rd_en)
            rd_reg <= mem[cmd.scan_addr];
    end

    assign lo_z = (CoordW+1)'(max_reg) - (CoordW+1)'(signed'({1'b0, band_width}));
    assign in_band = ((CoordW+1)'(signed'(rd_reg.z)) > lo_z)
                     && (signed'(rd_reg.z) < max_reg);

    assign tx = {rx_reg[CntW-1:0], qx_reg[SumW-1]} - {1'b0, bc_reg};
    assign ty = {ry_reg[CntW-1:0], qy_reg[SumW-1]} - {1'b0, bc_reg};
    assign tz = {rz_reg[CntW-1:0], qz_reg[SumW-1]} - {1'b0, bc_reg};
    assign cx_q = negx_reg ? -qx_reg : qx_reg;
    assign cy_q = negy_reg ? -qy_reg : qy_reg;
    assign cz_q = negz_reg ? -qz_reg : qz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.max_init)
            max_reg <= signed'(rd_reg.z);
        else if (cmd.max_acc && signed'(rd_reg.z) > max_reg)
            max_reg <= signed'(rd_reg.z);
        if (cmd.band_init)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
            bc_reg <= '0;
        end
        else if (cmd.band_acc && in_band)
        begin
            sx_reg <= sx_reg + SumW'(signed'(rd_reg.x));
            sy_reg <= sy_reg + SumW'(signed'(rd_reg.y));
            sz_reg <= sz_reg + SumW'(signed'(rd_reg.z));
            bc_reg <= bc_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            negx_reg <= sx_reg[SumW-1];
            negy_reg <= sy_reg[SumW-1];
            negz_reg <= sz_reg[SumW-1];
            qx_reg <= sx_reg[SumW-1] ? -sx_reg : sx_reg;
            qy_reg <= sy_reg[SumW-1] ? -sy_reg : sy_reg;
            qz_reg <= sz_reg[SumW-1] ? -sz_reg : sz_reg;
            rx_reg <= '0;
            ry_reg <= '0;
            rz_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!tx[CntW])
                rx_reg <= tx;
            else
                rx_reg <= {rx_reg[CntW-1:0], qx_reg[SumW-1]};
            qx_reg <= {qx_reg[SumW-2:0], !tx[CntW]};
            if (!ty[CntW])
                ry_reg <= ty;
            else
                ry_reg <= {ry_reg[CntW-1:0], qy_reg[SumW-1]};
            qy_reg <= {qy_reg[SumW-2:0], !ty[CntW]};
            if (!tz[CntW])
                rz_reg <= tz;
            else
                rz_reg <= {rz_reg[CntW-1:0], qz_reg[SumW-1]};
            qz_reg <= {qz_reg[SumW-2:0], !tz[CntW]};
        end
        if (cmd.fin_few)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            bco_reg <= '0;
            st_reg <= StatusFew;
            dom_reg <= (miss_reg > miss_limit);
        end
        else if (cmd.fin_norm)
        begin
            bco_reg <= bc_reg;
            dom_reg <= (miss_reg > miss_limit);
            if (bc_reg == '0)
            begin
                cx_reg <= '0;
                cy_reg <= '0;
                cz_reg <= '0;
                st_reg <= StatusEmpty;
            end
            else
            begin
                cx_reg <= cx_q[17:0];
                cy_reg <= cy_q[17:0];
                cz_reg <= cz_q[17:0];
                st_reg <= StatusOk;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            miss_reg <= '0;
            det_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_cnt)
                cnt_reg <= '0;
            else if (cmd.store_wr)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.clear_cnt)
                det_reg <= detection_seen;
            // Miss count moves once per counted cloud, at the start of the max pass.
            if (cmd.max_init)
            begin
                if (det_reg)
                    miss_reg <= '0;
                else if (miss_reg != 8'hFF)
                    miss_reg <= miss_reg + 1'b1;
            end
        end
    end

    assign centroid_x = cx_reg;
    assign centroid_y = cy_reg;
    assign centroid_z = cz_reg;
    assign band_count = bco_reg;
    assign status = st_reg;
    assign depth_only_mode = dom_reg;
endmodule

[rtl/core/top_band_centroid.sv]
// Points load at one item per cycle while in_pt.ready is high.
// After the last point of a cloud: a max-z pass, then a band pass over the store,
// then the three shared-step dividers, then a step that forms the result.
// A too-few cloud skips the passes and the division and goes straight to its result.
// rst_n clears the counters and loads register defaults; the store needs no clearing.
module top_band_centroid (
    input  logic        clk,
    input  logic        rst_n,
    tbc_stream_if.sink   in_pt,
    tbc_stream_if.source out_res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    import tbc_pkg::*;

    logic [13:0] bw_reg;
    logic [10:0] mp_reg;
    logic [7:0] ml_reg;
    tbc_cmd_t cmd;
    tbc_stat_t stat;
    point_t pt;
    logic [17:0] cx, cy, cz;
    logic [10:0] bc;
    logic [1:0] st;
    logic dom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= 14'd100;
            mp_reg <= 11'd20;
            ml_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegBandWidth: bw_reg <= cfg_data;
                RegMinPoints: mp_reg <= cfg_data[10:0];
                RegMissLimit: ml_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input data: {x, y, z, detection_seen, last_point}, 56 bits.
    assign pt.x = in_pt.data[55:38];
    assign pt.y = in_pt.data[37:20];
    assign pt.z = in_pt.data[19:2];

    tbc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_pt.valid), .in_last(in_pt.data[0]), .in_ready(in_pt.ready),
        .out_valid(out_res.valid), .out_ready(out_res.ready),
        .min_points(mp_reg), .stat(stat), .cmd(cmd)
    );

    tbc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .pt(pt), .detection_seen(in_pt.data[1]),
        .band_width(bw_reg), .miss_limit(ml_reg), .cmd(cmd), .stat(stat),
        .centroid_x(cx), .centroid_y(cy), .centroid_z(cz),
        .band_count(bc), .status(st), .depth_only_mode(dom)
    );

    // Output data: {x, y, z, band_count, status, depth_only_mode}, 68 bits.
    assign out_res.data = {cx, cy, cz, bc, st, dom};
endmodule
